>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the ray/box slab test block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RBSFU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication violated");

// next-cycle implication, disabled while reset is asserted
`define RBSFU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`endif

>>> src/rbsfu_pkg.sv
// ----------------------------------------------------------------------------
// rbsfu_pkg
// types and constants shared by the ray/box slab test pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rbsfu_pkg;

    // face u/v format
    localparam int          UV_BITS  = 16;
    localparam logic [16:0] UV_ONE   = 17'h10000;
    localparam logic [30:0] DIST_MAX = 31'h7fffffff;

    // face codes
    localparam logic [2:0] FACE_NEG_Z = 3'd0;
    localparam logic [2:0] FACE_POS_Z = 3'd1;
    localparam logic [2:0] FACE_POS_X = 3'd2;
    localparam logic [2:0] FACE_NEG_X = 3'd3;
    localparam logic [2:0] FACE_POS_Y = 3'd4;
    localparam logic [2:0] FACE_NEG_Y = 3'd5;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_MIN_X = 3'd0;
    localparam logic [2:0] CFG_MIN_Y = 3'd1;
    localparam logic [2:0] CFG_MIN_Z = 3'd2;
    localparam logic [2:0] CFG_MAX_X = 3'd3;
    localparam logic [2:0] CFG_MAX_Y = 3'd4;
    localparam logic [2:0] CFG_MAX_Z = 3'd5;

    // ray request
    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] direction_x;
        logic signed [31:0] direction_y;
        logic signed [31:0] direction_z;
    } t_ray_req;

    // ray result
    typedef struct packed {
        logic        hit;
        logic [30:0] entry_dist;
        logic [2:0]  entry_face;
        logic [16:0] entry_u;
        logic [16:0] entry_v;
        logic [30:0] exit_dist;
        logic [2:0]  exit_face;
        logic [16:0] exit_u;
        logic [16:0] exit_v;
    } t_ray_res;

    // one hit point to evaluate: slab stage to face stage
    typedef struct packed {
        logic        hit;
        logic [1:0]  axis;
        logic        neg;
        logic [30:0] distance;
    } t_point_req;

    // evaluated hit point
    typedef struct packed {
        logic        hit;
        logic [30:0] distance;
        logic [2:0]  face;
        logic [16:0] u;
        logic [16:0] v;
    } t_point_res;

    // context riding alongside the slab dividers; qneg[2i] lower bound, [2i+1] upper
    typedef struct packed {
        t_ray_req   req;
        logic [5:0] qneg;
    } t_div_ctx;

endpackage

`default_nettype wire

>>> src/rbsfu_udiv.sv
// ----------------------------------------------------------------------------
// rbsfu_udiv
// pipelined restoring unsigned divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rbsfu_udiv #(
    parameter int NW = 49,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [DW-1:0] i_rem0,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_vld,
    output logic [NW-1:0] o_quo
);

    logic          r_vld [NW];
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_nq  [NW];
    logic [DW-1:0] r_den [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          vld_in;
        logic [DW-1:0] rem_in;
        logic [NW-1:0] nq_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   sh;
        logic [DW+1:0] dif;

        // stage source
        if (k == 0) begin : g_first
            assign vld_in = i_vld;
            assign rem_in = i_rem0;
            assign nq_in  = i_num;
            assign den_in = i_den;
        end else begin : g_next
            assign vld_in = r_vld[k-1];
            assign rem_in = r_rem[k-1];
            assign nq_in  = r_nq[k-1];
            assign den_in = r_den[k-1];
        end

        // trial subtract of the shifted remainder
        assign sh  = {rem_in, nq_in[NW-1]};
        assign dif = {1'b0, sh} - {2'b00, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
            r_den[k] <= den_in;
            if (dif[DW+1]) begin
                r_rem[k] <= sh[DW-1:0];
                r_nq[k]  <= {nq_in[NW-2:0], 1'b0};
            end else begin
                r_rem[k] <= dif[DW-1:0];
                r_nq[k]  <= {nq_in[NW-2:0], 1'b1};
            end
        end
    end

    assign o_vld = r_vld[NW-1];
    assign o_quo = r_nq[NW-1];

endmodule

`default_nettype wire

>>> src/rbsfu_slab.sv
// ----------------------------------------------------------------------------
// rbsfu_slab
// slab interval ordering, entry/exit reduction and hit decision
// ----------------------------------------------------------------------------
`default_nettype none

module rbsfu_slab #(
    parameter int QW = 49
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  rbsfu_pkg::t_div_ctx      i_ctx,
    input  logic [5:0][QW-1:0]       i_quo,
    input  logic [2:0][31:0]         i_lo,
    input  logic [2:0][31:0]         i_hi,
    output logic                     o_vld,
    output rbsfu_pkg::t_ray_req      o_req,
    output rbsfu_pkg::t_point_req    o_entry,
    output rbsfu_pkg::t_point_req    o_exit
);

    localparam int TW = QW + 1;

    logic signed [31:0] w_o [3];
    logic signed [31:0] w_d [3];

    assign w_o[0] = i_ctx.req.origin_x;
    assign w_o[1] = i_ctx.req.origin_y;
    assign w_o[2] = i_ctx.req.origin_z;
    assign w_d[0] = i_ctx.req.direction_x;
    assign w_d[1] = i_ctx.req.direction_y;
    assign w_d[2] = i_ctx.req.direction_z;

    // stage 1: signed slab distances, ordered per axis
    logic signed [TW-1:0] n1_near [3];
    logic signed [TW-1:0] n1_far  [3];
    logic                 n1_en   [3];
    logic                 n1_par  [3];
    logic                 n1_out  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [TW-1:0] ta;
            logic signed [TW-1:0] tb;
            ta = $signed({1'b0, i_quo[2*i]});
            tb = $signed({1'b0, i_quo[2*i+1]});
            if (i_ctx.qneg[2*i]) ta = -ta;
            if (i_ctx.qneg[2*i+1]) tb = -tb;
            n1_par[i] = (w_d[i] == 32'sd0);
            n1_out[i] = (w_o[i] < $signed(i_lo[i])) || (w_o[i] > $signed(i_hi[i]));
            if (ta > tb) begin
                n1_near[i] = tb;
                n1_far[i]  = ta;
                n1_en[i]   = 1'b0;
            end else begin
                n1_near[i] = ta;
                n1_far[i]  = tb;
                n1_en[i]   = 1'b1;
            end
        end
    end

    logic                 r1_vld;
    rbsfu_pkg::t_ray_req  r1_req;
    logic signed [TW-1:0] r1_near [3];
    logic signed [TW-1:0] r1_far  [3];
    logic                 r1_en   [3];
    logic                 r1_par  [3];
    logic                 r1_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_req  <= i_ctx.req;
        r1_miss <= (n1_par[0] && n1_out[0]) || (n1_par[1] && n1_out[1]) ||
                   (n1_par[2] && n1_out[2]);
        for (int i = 0; i < 3; i++) begin
            r1_near[i] <= n1_near[i];
            r1_far[i]  <= n1_far[i];
            r1_en[i]   <= n1_en[i];
            r1_par[i]  <= n1_par[i];
        end
    end

    // stage 2: latest entry and earliest exit, lower axis wins ties
    logic                 n2_have;
    logic signed [TW-1:0] n2_tmin;
    logic signed [TW-1:0] n2_tmax;
    logic [1:0]           n2_eax;
    logic                 n2_eneg;
    logic [1:0]           n2_xax;
    logic                 n2_xneg;

    always_comb begin
        n2_have = 1'b0;
        n2_tmin = '0;
        n2_tmax = '0;
        n2_eax  = rbsfu_pkg::AXIS_X;
        n2_eneg = 1'b0;
        n2_xax  = rbsfu_pkg::AXIS_X;
        n2_xneg = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (!r1_par[i]) begin
                if (!n2_have || r1_near[i] > n2_tmin) begin
                    n2_tmin = r1_near[i];
                    n2_eax  = 2'(i);
                    n2_eneg = r1_en[i];
                end
                if (!n2_have || r1_far[i] < n2_tmax) begin
                    n2_tmax = r1_far[i];
                    n2_xax  = 2'(i);
                    n2_xneg = !r1_en[i];
                end
                n2_have = 1'b1;
            end
        end
    end

    logic                 r2_vld;
    rbsfu_pkg::t_ray_req  r2_req;
    logic                 r2_have;
    logic                 r2_miss;
    logic signed [TW-1:0] r2_tmin;
    logic signed [TW-1:0] r2_tmax;
    logic [1:0]           r2_eax;
    logic                 r2_eneg;
    logic [1:0]           r2_xax;
    logic                 r2_xneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_req  <= r1_req;
        r2_have <= n2_have;
        r2_miss <= r1_miss;
        r2_tmin <= n2_tmin;
        r2_tmax <= n2_tmax;
        r2_eax  <= n2_eax;
        r2_eneg <= n2_eneg;
        r2_xax  <= n2_xax;
        r2_xneg <= n2_xneg;
    end

    // clamp a distance to the unsigned output range
    function automatic logic [30:0] sat_dist(input logic signed [TW-1:0] t);
        logic [30:0] res;
        if (t[TW-1]) begin
            res = '0;
        end else if (|t[TW-2:31]) begin
            res = rbsfu_pkg::DIST_MAX;
        end else begin
            res = t[30:0];
        end
        return res;
    endfunction

    // stage 3: hit decision, fall back to exit when origin is inside
    logic                 n3_hit;
    logic                 n3_inside;
    logic signed [TW-1:0] n3_thit;

    assign n3_hit    = r2_have && !r2_miss && !(r2_tmin > r2_tmax) && !r2_tmax[TW-1];
    assign n3_inside = r2_tmin[TW-1];
    assign n3_thit   = n3_inside ? r2_tmax : r2_tmin;

    logic                  r3_vld;
    rbsfu_pkg::t_ray_req   r3_req;
    rbsfu_pkg::t_point_req r3_entry;
    rbsfu_pkg::t_point_req r3_exit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_req            <= r2_req;
        r3_entry.hit      <= n3_hit;
        r3_entry.axis     <= n3_inside ? r2_xax : r2_eax;
        r3_entry.neg      <= n3_inside ? r2_xneg : r2_eneg;
        r3_entry.distance <= sat_dist(n3_thit);
        r3_exit.hit       <= n3_hit;
        r3_exit.axis      <= r2_xax;
        r3_exit.neg       <= r2_xneg;
        r3_exit.distance  <= sat_dist(r2_tmax);
    end

    assign o_vld   = r3_vld;
    assign o_req   = r3_req;
    assign o_entry = r3_entry;
    assign o_exit  = r3_exit;

endmodule

`default_nettype wire

>>> src/rbsfu_face.sv
// ----------------------------------------------------------------------------
// rbsfu_face
// hit point, face code and clamped face u/v for one distance
// ----------------------------------------------------------------------------
`default_nettype none

module rbsfu_face #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  rbsfu_pkg::t_point_req  i_pt,
    input  rbsfu_pkg::t_ray_req    i_req,
    input  logic [2:0][31:0]       i_lo,
    input  logic [2:0][31:0]       i_hi,
    output logic                   o_vld,
    output rbsfu_pkg::t_point_res  o_pt
);

    localparam int          MW       = 63 - FRAC_BITS;
    localparam int          PW       = MW + 2;
    localparam int          DFW      = PW + 1;
    localparam int          UVW      = rbsfu_pkg::UV_BITS;
    localparam logic [32:0] SIZE_ONE = 33'd1 << FRAC_BITS;

    typedef struct packed {
        rbsfu_pkg::t_point_req pt;
        logic                  a_zero;
        logic                  a_one;
        logic                  b_zero;
        logic                  b_one;
    } t_uv_ctx;

    logic signed [31:0] w_o [3];
    logic signed [31:0] w_d [3];

    assign w_o[0] = i_req.origin_x;
    assign w_o[1] = i_req.origin_y;
    assign w_o[2] = i_req.origin_z;
    assign w_d[0] = i_req.direction_x;
    assign w_d[1] = i_req.direction_y;
    assign w_d[2] = i_req.direction_z;

    // stage 1: |direction| times distance
    logic [31:0] w_dmag [3];
    logic [62:0] w_prod [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dmag[i] = w_d[i][31] ? 32'(-w_d[i]) : 32'(w_d[i]);
            w_prod[i] = {31'b0, w_dmag[i]} * {32'b0, i_pt.distance};
        end
    end

    logic                  r1_vld;
    rbsfu_pkg::t_point_req r1_pt;
    logic [62:0]           r1_prod [3];
    logic                  r1_dneg [3];
    logic signed [31:0]    r1_o    [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_pt <= i_pt;
        for (int i = 0; i < 3; i++) begin
            r1_prod[i] <= w_prod[i];
            r1_dneg[i] <= w_d[i][31];
            r1_o[i]    <= w_o[i];
        end
    end

    // stage 2: point = origin + signed truncated product
    logic signed [PW-1:0] w_p [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [PW-1:0] mv;
            mv = $signed({2'b00, r1_prod[i][62:FRAC_BITS]});
            if (r1_dneg[i]) mv = -mv;
            w_p[i] = mv + $signed({{(PW-32){r1_o[i][31]}}, r1_o[i]});
        end
    end

    logic                  r2_vld;
    rbsfu_pkg::t_point_req r2_pt;
    logic signed [PW-1:0]  r2_p [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_pt <= r1_pt;
        for (int i = 0; i < 3; i++) begin
            r2_p[i] <= w_p[i];
        end
    end

    // offsets into the box and clamp flags for every coordinate
    logic [32:0] w_rem  [3];
    logic [32:0] w_size [3];
    logic        w_zero [3];
    logic        w_one  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [DFW-1:0] diff;
            logic signed [32:0]    ext;
            diff = $signed({r2_p[i][PW-1], r2_p[i]}) -
                   $signed({{(DFW-32){i_lo[i][31]}}, i_lo[i]});
            ext  = $signed({i_hi[i][31], i_hi[i]}) - $signed({i_lo[i][31], i_lo[i]});
            w_size[i] = (ext[32] || ext == 33'sd0) ? SIZE_ONE : ext;
            w_zero[i] = diff[DFW-1] || diff == '0;
            w_one[i]  = diff >= $signed({{(DFW-33){1'b0}}, w_size[i]});
            w_rem[i]  = diff[32:0];
        end
    end

    // coordinate pair on the face
    logic [32:0] w_a_rem, w_a_size, w_b_rem, w_b_size;
    logic        w_a_zero, w_a_one, w_b_zero, w_b_one;

    always_comb begin
        case (r2_pt.axis)
            rbsfu_pkg::AXIS_Z: begin
                w_a_rem = w_rem[0]; w_a_size = w_size[0];
                w_a_zero = w_zero[0]; w_a_one = w_one[0];
                w_b_rem = w_rem[1]; w_b_size = w_size[1];
                w_b_zero = w_zero[1]; w_b_one = w_one[1];
            end
            rbsfu_pkg::AXIS_X: begin
                w_a_rem = w_rem[2]; w_a_size = w_size[2];
                w_a_zero = w_zero[2]; w_a_one = w_one[2];
                w_b_rem = w_rem[1]; w_b_size = w_size[1];
                w_b_zero = w_zero[1]; w_b_one = w_one[1];
            end
            default: begin
                w_a_rem = w_rem[0]; w_a_size = w_size[0];
                w_a_zero = w_zero[0]; w_a_one = w_one[0];
                w_b_rem = w_rem[2]; w_b_size = w_size[2];
                w_b_zero = w_zero[2]; w_b_one = w_one[2];
            end
        endcase
    end

    // fraction dividers
    logic           w_div_vld;
    logic [UVW-1:0] w_qa;
    logic [UVW-1:0] w_qb;

    rbsfu_udiv #(.NW(UVW), .DW(33)) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .i_rem0  (w_a_rem),
        .i_num   ('0),
        .i_den   (w_a_size),
        .o_vld   (w_div_vld),
        .o_quo   (w_qa)
    );

    rbsfu_udiv #(.NW(UVW), .DW(33)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .i_rem0  (w_b_rem),
        .i_num   ('0),
        .i_den   (w_b_size),
        .o_vld   (),
        .o_quo   (w_qb)
    );

    // context alongside the dividers
    t_uv_ctx r_dly [UVW];

    always_ff @(posedge i_clk) begin
        r_dly[0] <= '{pt: r2_pt, a_zero: w_a_zero, a_one: w_a_one,
                      b_zero: w_b_zero, b_one: w_b_one};
        for (int k = 1; k < UVW; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    // final stage: clamp, orient and code the face
    t_uv_ctx     w_c;
    logic [16:0] w_la, w_lb;
    rbsfu_pkg::t_point_res n4_pt;

    assign w_c  = r_dly[UVW-1];
    assign w_la = w_c.a_zero ? 17'd0 : (w_c.a_one ? rbsfu_pkg::UV_ONE : {1'b0, w_qa});
    assign w_lb = w_c.b_zero ? 17'd0 : (w_c.b_one ? rbsfu_pkg::UV_ONE : {1'b0, w_qb});

    always_comb begin
        n4_pt.hit      = w_c.pt.hit;
        n4_pt.distance = w_c.pt.distance;
        case (w_c.pt.axis)
            rbsfu_pkg::AXIS_Z: begin
                n4_pt.face = w_c.pt.neg ? rbsfu_pkg::FACE_NEG_Z : rbsfu_pkg::FACE_POS_Z;
                n4_pt.u    = w_c.pt.neg ? rbsfu_pkg::UV_ONE - w_la : w_la;
                n4_pt.v    = rbsfu_pkg::UV_ONE - w_lb;
            end
            rbsfu_pkg::AXIS_X: begin
                n4_pt.face = w_c.pt.neg ? rbsfu_pkg::FACE_NEG_X : rbsfu_pkg::FACE_POS_X;
                n4_pt.u    = w_c.pt.neg ? w_la : rbsfu_pkg::UV_ONE - w_la;
                n4_pt.v    = rbsfu_pkg::UV_ONE - w_lb;
            end
            default: begin
                n4_pt.face = w_c.pt.neg ? rbsfu_pkg::FACE_NEG_Y : rbsfu_pkg::FACE_POS_Y;
                n4_pt.u    = w_la;
                n4_pt.v    = w_c.pt.neg ? rbsfu_pkg::UV_ONE - w_lb : w_lb;
            end
        endcase
        // a miss reports all zero
        if (!w_c.pt.hit) begin
            n4_pt = '0;
        end
    end

    logic                  r4_vld;
    rbsfu_pkg::t_point_res r4_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= w_div_vld;
        end
        r4_pt <= n4_pt;
    end

    assign o_vld = r4_vld;
    assign o_pt  = r4_pt;

endmodule

`default_nettype wire

>>> src/ray_box_slab_face_uv.sv
// ----------------------------------------------------------------------------
// ray_box_slab_face_uv
// ray against axis-aligned box slab test with entry/exit faces and face u/v
// ----------------------------------------------------------------------------
// the slab dividers give one stage per quotient bit, 33 + FRAC_BITS stages
// throughput: one request per cycle, busy stays low, results are never held
// reset: clears every pipeline valid bit and loads the unit box into the
//   bound registers; no result strobes until requests arrive after reset
`default_nettype none

`include "assert_macros.svh"

module ray_box_slab_face_uv #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rbsfu_pkg::t_ray_req  i_req,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_valid,
    output rbsfu_pkg::t_ray_res  o_res
);

    localparam int QW = 33 + FRAC_BITS;

    assign busy = 1'b0;

    // box bound registers
    logic [2:0][31:0] r_box_lo;
    logic [2:0][31:0] r_box_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_lo <= '{default: 32'h0000_0000};
            r_box_hi <= '{default: 32'h0001_0000};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbsfu_pkg::CFG_MIN_X: r_box_lo[0] <= i_cfg_data;
                rbsfu_pkg::CFG_MIN_Y: r_box_lo[1] <= i_cfg_data;
                rbsfu_pkg::CFG_MIN_Z: r_box_lo[2] <= i_cfg_data;
                rbsfu_pkg::CFG_MAX_X: r_box_hi[0] <= i_cfg_data;
                rbsfu_pkg::CFG_MAX_Y: r_box_hi[1] <= i_cfg_data;
                rbsfu_pkg::CFG_MAX_Z: r_box_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    logic                r_s0_vld;
    rbsfu_pkg::t_ray_req r_s0_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= start && !busy;
        end
        r_s0_req <= i_req;
    end

    // slab numerators and divisors as magnitude and sign
    logic signed [31:0] w_o [3];
    logic signed [31:0] w_d [3];
    logic [QW-1:0]      w_num  [6];
    logic [31:0]        w_dmag [3];
    logic [5:0]         w_qneg;

    assign w_o[0] = r_s0_req.origin_x;
    assign w_o[1] = r_s0_req.origin_y;
    assign w_o[2] = r_s0_req.origin_z;
    assign w_d[0] = r_s0_req.direction_x;
    assign w_d[1] = r_s0_req.direction_y;
    assign w_d[2] = r_s0_req.direction_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [32:0] al;
            logic signed [32:0] ah;
            logic [32:0]        ml;
            logic [32:0]        mh;
            al = $signed({r_box_lo[i][31], r_box_lo[i]}) - $signed({w_o[i][31], w_o[i]});
            ah = $signed({r_box_hi[i][31], r_box_hi[i]}) - $signed({w_o[i][31], w_o[i]});
            ml = al[32] ? 33'(-al) : 33'(al);
            mh = ah[32] ? 33'(-ah) : 33'(ah);
            w_num[2*i]     = {ml, {FRAC_BITS{1'b0}}};
            w_num[2*i+1]   = {mh, {FRAC_BITS{1'b0}}};
            w_dmag[i]      = w_d[i][31] ? 32'(-w_d[i]) : 32'(w_d[i]);
            w_qneg[2*i]    = al[32] ^ w_d[i][31];
            w_qneg[2*i+1]  = ah[32] ^ w_d[i][31];
        end
    end

    // six slab dividers
    logic [5:0][QW-1:0] w_quo;
    logic               w_div_vld;

    for (genvar j = 0; j < 6; j++) begin : g_div
        if (j == 0) begin : g_lead
            rbsfu_udiv #(.NW(QW), .DW(32)) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_vld   (r_s0_vld),
                .i_rem0  ('0),
                .i_num   (w_num[j]),
                .i_den   (w_dmag[j/2]),
                .o_vld   (w_div_vld),
                .o_quo   (w_quo[j])
            );
        end else begin : g_rest
            rbsfu_udiv #(.NW(QW), .DW(32)) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_vld   (r_s0_vld),
                .i_rem0  ('0),
                .i_num   (w_num[j]),
                .i_den   (w_dmag[j/2]),
                .o_vld   (),
                .o_quo   (w_quo[j])
            );
        end
    end

    // request context alongside the dividers
    rbsfu_pkg::t_div_ctx r_dly [QW];

    always_ff @(posedge i_clk) begin
        r_dly[0] <= '{req: r_s0_req, qneg: w_qneg};
        for (int k = 1; k < QW; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    // slab reduction
    logic                  w_slab_vld;
    rbsfu_pkg::t_ray_req   w_slab_req;
    rbsfu_pkg::t_point_req w_entry_req;
    rbsfu_pkg::t_point_req w_exit_req;

    rbsfu_slab #(.QW(QW)) u_slab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_div_vld),
        .i_ctx   (r_dly[QW-1]),
        .i_quo   (w_quo),
        .i_lo    (r_box_lo),
        .i_hi    (r_box_hi),
        .o_vld   (w_slab_vld),
        .o_req   (w_slab_req),
        .o_entry (w_entry_req),
        .o_exit  (w_exit_req)
    );

    // entry and exit points
    logic                  w_exit_vld;
    rbsfu_pkg::t_point_res w_entry;
    rbsfu_pkg::t_point_res w_exit;

    rbsfu_face #(.FRAC_BITS(FRAC_BITS)) u_face_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_slab_vld),
        .i_pt    (w_entry_req),
        .i_req   (w_slab_req),
        .i_lo    (r_box_lo),
        .i_hi    (r_box_hi),
        .o_vld   (o_valid),
        .o_pt    (w_entry)
    );

    rbsfu_face #(.FRAC_BITS(FRAC_BITS)) u_face_exit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_slab_vld),
        .i_pt    (w_exit_req),
        .i_req   (w_slab_req),
        .i_lo    (r_box_lo),
        .i_hi    (r_box_hi),
        .o_vld   (w_exit_vld),
        .o_pt    (w_exit)
    );

    // result assembly
    assign o_res.hit        = w_entry.hit;
    assign o_res.entry_dist = w_entry.distance;
    assign o_res.entry_face = w_entry.face;
    assign o_res.entry_u    = w_entry.u;
    assign o_res.entry_v    = w_entry.v;
    assign o_res.exit_dist  = w_exit.distance;
    assign o_res.exit_face  = w_exit.face;
    assign o_res.exit_u     = w_exit.u;
    assign o_res.exit_v     = w_exit.v;

    // checks
    `RBSFU_ASSERT_IMP(a_face_align, i_clk, i_rst_n, 1'b1, o_valid == w_exit_vld)
    `RBSFU_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_valid && !o_res.hit, o_res.entry_dist == 31'd0 && o_res.exit_dist == 31'd0 && o_res.entry_u == 17'd0 && o_res.exit_v == 17'd0)
    `RBSFU_ASSERT_IMP(a_dist_order, i_clk, i_rst_n, o_valid && o_res.hit, o_res.entry_dist <= o_res.exit_dist)
    `RBSFU_ASSERT_IMP(a_uv_range, i_clk, i_rst_n, o_valid, o_res.entry_u <= rbsfu_pkg::UV_ONE && o_res.entry_v <= rbsfu_pkg::UV_ONE && o_res.exit_u <= rbsfu_pkg::UV_ONE && o_res.exit_v <= rbsfu_pkg::UV_ONE)

endmodule

`default_nettype wire
